// ===== sv/las_pkg.sv =====
`timescale 1ns / 1ps

package las_pkg;

  // Default grid edge length, in cells
  localparam int GRID_DIM_DEF = 64;

  // Field widths of the command and response words
  localparam int CMD_W   = 2;
  localparam int COORD_W = 6;

  // Neighbor counts of the B3/S23 rule
  localparam logic [3:0] BIRTH_CNT = 4'd3;
  localparam logic [3:0] KEEP_CNT  = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } las_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } las_state_e;

  // Controller to datapath
  typedef struct packed {
    logic cell_wr;      // write one cell from the command word
    logic cell_rd;      // issue a row read for a cell read
    logic out_now;      // load a response with no cell data
    logic out_read;     // load a response from the row just read
    logic sweep_start;  // clear the window and the row counter
    logic sweep_run;    // advance the generation sweep
    logic out_step;     // load the response that closes a step
  } las_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;     // response register full and not taken this cycle
    logic sweep_last;   // final cycle of the sweep
  } las_sts_t;

  // Next state of the center cell of a 3x3 window
  function automatic logic life_rule(logic [2:0] up, logic [2:0] mid, logic [2:0] dn);
    logic [3:0] n;
    n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
      + 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
    return (n == BIRTH_CNT) || (mid[1] && (n == KEEP_CNT));
  endfunction

endpackage

// ===== sv/las_if.sv =====
`timescale 1ns / 1ps

interface las_cmd_if import las_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic               alive_in;

  modport source (output valid, cmd, row, col, alive_in, input ready);
  modport sink   (input valid, cmd, row, col, alive_in, output ready);
endinterface

interface las_rsp_if import las_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cell_alive;
  logic [CMD_W-1:0] done_cmd;

  modport source (output valid, cell_alive, done_cmd, input ready);
  modport sink   (input valid, cell_alive, done_cmd, output ready);
endinterface

// ===== sv/las_ctrl.sv =====
`timescale 1ns / 1ps

module las_ctrl import las_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  logic [CMD_W-1:0] cmd_code_i,
  output logic             cmd_ready_o,
  input  las_sts_t         sts_i,
  output las_ctl_t         ctl_o
);

  las_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !sts_i.out_busy) begin
          case (cmd_code_i)
            CMD_READ: state_d = ST_READ;
            CMD_STEP: state_d = ST_SWEEP;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_SWEEP: begin
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o       = '0;
    cmd_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // take a word only when the response slot is free by the next edge
        cmd_ready_o = !sts_i.out_busy;
        if (cmd_valid_i && !sts_i.out_busy) begin
          case (cmd_code_i)
            CMD_WRITE: begin
              ctl_o.cell_wr = 1'b1;
              ctl_o.out_now = 1'b1;
            end
            CMD_READ: ctl_o.cell_rd     = 1'b1;
            CMD_STEP: ctl_o.sweep_start = 1'b1;
            default:  ctl_o.out_now     = 1'b1;
          endcase
        end
      end
      ST_READ: ctl_o.out_read = 1'b1;
      ST_SWEEP: begin
        ctl_o.sweep_run = 1'b1;
        ctl_o.out_step  = sts_i.sweep_last;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_read_answers_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.cell_rd |=> ctl_o.out_read)
    else $error("cell read did not load its response on the next cycle");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.out_now || ctl_o.out_read || ctl_o.out_step) |-> !sts_i.out_busy)
    else $error("response loaded while the previous one is still held");

  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.out_now, ctl_o.out_read, ctl_o.out_step}))
    else $error("more than one response source selected");

  a_sweep_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.sweep_start |=> (ctl_o.sweep_run && !ctl_o.out_step))
    else $error("sweep did not begin after a step command");
`endif

endmodule

// ===== sv/las_datapath.sv =====
`timescale 1ns / 1ps

module las_datapath import las_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  las_ctl_t           ctl_i,
  output las_sts_t           sts_o,
  input  logic [CMD_W-1:0]   cmd_code_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic               alive_in_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic               rsp_cell_alive_o,
  output logic [CMD_W-1:0]   rsp_done_cmd_o
);

  localparam int AddrW = $clog2(GRID_DIM);
  localparam int CntW  = $clog2(GRID_DIM + 2);

  // Row store, one row per entry; an entry never written reads as all dead
  logic [GRID_DIM-1:0] grid_mem [GRID_DIM];
  logic [GRID_DIM-1:0] row_valid_q;

  logic [GRID_DIM-1:0] rd_data_q;
  logic                rd_valid_q;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;
  logic [GRID_DIM-1:0] rd_row;

  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [GRID_DIM-1:0] mem_wmask;
  logic [GRID_DIM-1:0] mem_wdata;

  logic [CntW-1:0]     cnt_q;
  logic                sweep_rd;
  logic                sweep_wr;
  logic [GRID_DIM-1:0] win_up_q;
  logic [GRID_DIM-1:0] win_mid_q;
  logic [GRID_DIM-1:0] win_dn;
  logic [GRID_DIM+1:0] up_x;
  logic [GRID_DIM+1:0] mid_x;
  logic [GRID_DIM+1:0] dn_x;
  logic [GRID_DIM-1:0] next_row;

  logic                in_inside;
  logic [AddrW-1:0]    in_row;
  logic [AddrW-1:0]    in_col;
  logic [GRID_DIM-1:0] col_onehot;
  logic [AddrW-1:0]    col_q;
  logic                inside_q;

  logic                out_valid_q;
  logic                out_cell_q;
  logic [CMD_W-1:0]    out_cmd_q;

  assign in_inside  = (32'(row_i) < 32'(GRID_DIM)) && (32'(col_i) < 32'(GRID_DIM));
  assign in_row     = AddrW'(row_i);
  assign in_col     = AddrW'(col_i);
  assign col_onehot = GRID_DIM'(1) << in_col;

  // Sweep: read row c at count c, write next generation of row c-2 at count c
  assign sweep_rd = ctl_i.sweep_run && (cnt_q < CntW'(GRID_DIM));
  assign sweep_wr = ctl_i.sweep_run && (cnt_q >= CntW'(2));

  assign rd_en   = ctl_i.cell_rd || sweep_rd;
  assign rd_addr = ctl_i.sweep_run ? cnt_q[AddrW-1:0] : in_row;
  assign rd_row  = rd_valid_q ? rd_data_q : '0;

  assign win_dn = (cnt_q == CntW'(GRID_DIM + 1)) ? '0 : rd_row;

  always_comb begin
    up_x  = {1'b0, win_up_q, 1'b0};
    mid_x = {1'b0, win_mid_q, 1'b0};
    dn_x  = {1'b0, win_dn, 1'b0};
    for (int j = 0; j < GRID_DIM; j++) begin
      next_row[j] = life_rule(up_x[j +: 3], mid_x[j +: 3], dn_x[j +: 3]);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_row;
    mem_wmask = '1;
    mem_wdata = next_row;
    if (sweep_wr) begin
      mem_we    = 1'b1;
      mem_waddr = AddrW'(cnt_q - CntW'(2));
    end else if (ctl_i.cell_wr && in_inside) begin
      mem_we = 1'b1;
      if (row_valid_q[in_row]) begin
        mem_wmask = col_onehot;
        mem_wdata = {GRID_DIM{alive_in_i}};
      end else begin
        // first touch of a row: fill the rest of it with dead cells
        mem_wdata = col_onehot & {GRID_DIM{alive_in_i}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < GRID_DIM; b++) begin
        if (mem_wmask[b]) grid_mem[mem_waddr][b] <= mem_wdata[b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= grid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (mem_we) row_valid_q[mem_waddr] <= 1'b1;
      if (rd_en) rd_valid_q <= row_valid_q[rd_addr];
      if (ctl_i.sweep_start) begin
        cnt_q <= '0;
      end else if (ctl_i.sweep_run) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // Window of old rows: shift once each fetched row lands
  always_ff @(posedge clk_i) begin
    if (ctl_i.sweep_start) begin
      win_up_q  <= '0;
      win_mid_q <= '0;
    end else if (ctl_i.sweep_run && (cnt_q != '0)) begin
      win_up_q  <= win_mid_q;
      win_mid_q <= win_dn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cell_rd) begin
      col_q    <= in_col;
      inside_q <= in_inside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_now || ctl_i.out_read || ctl_i.out_step) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_now) begin
      out_cell_q <= 1'b0;
      out_cmd_q  <= cmd_code_i;
    end else if (ctl_i.out_read) begin
      out_cell_q <= inside_q && rd_row[col_q];
      out_cmd_q  <= CMD_READ;
    end else if (ctl_i.out_step) begin
      out_cell_q <= 1'b0;
      out_cmd_q  <= CMD_STEP;
    end
  end

  assign sts_o.out_busy   = out_valid_q && !rsp_ready_i;
  assign sts_o.sweep_last = (cnt_q == CntW'(GRID_DIM + 1));

  assign rsp_valid_o      = out_valid_q;
  assign rsp_cell_alive_o = out_cell_q;
  assign rsp_done_cmd_o   = out_cmd_q;

endmodule

// ===== sv/life_automaton_step_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Word                              Handshake
// cmd_i    in   cmd, row, col, alive_in           valid/ready
// rsp_o    out  cell_alive, done_cmd              valid/ready
//
// Cell write and unused command: one word per cycle while each response is taken at once.
// Cell read: the response comes from the registered read of the row store.
// Step: a row-serial sweep through the single read port.
// Reset clears the grid at once through per-row valid bits; no clearing pass.
// cmd_i.ready drops while a response waits untaken and during reads and steps.

module life_automaton_step_core import las_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  las_cmd_if.sink   cmd_i,
  las_rsp_if.source rsp_o
);

  las_ctl_t ctl;
  las_sts_t sts;

  las_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_code_i  (cmd_i.cmd),
    .cmd_ready_o (cmd_i.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  las_datapath #(
    .GRID_DIM (GRID_DIM)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .cmd_code_i       (cmd_i.cmd),
    .row_i            (cmd_i.row),
    .col_i            (cmd_i.col),
    .alive_in_i       (cmd_i.alive_in),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_cell_alive_o (rsp_o.cell_alive),
    .rsp_done_cmd_o   (rsp_o.done_cmd)
  );

endmodule
